// ===== hdl/llace_pkg.sv =====
// Shared types, constants and instruction encodings for the loop-language code emitter.
// Used by the front, queue, back and top-level modules; depends on nothing else.
package llace_pkg;

    localparam int STACK_DEPTH = 128;
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int STACK_DW    = STACK_AW + 1;
    localparam int CODE_AW     = 16;
    localparam int CODE_WORDS  = 1 << CODE_AW;
    localparam int WI_W        = CODE_AW + 1;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] OP_ADD   = 32'he2800000;
    localparam logic [31:0] OP_SUB   = 32'he2400000;
    localparam logic [31:0] OP_STRBR = 32'he4c10000;
    localparam logic [31:0] OP_STRBL = 32'he4410000;
    localparam logic [31:0] OP_LDRB  = 32'he5d10000;
    localparam logic [31:0] OP_TST   = 32'he31000ff;
    localparam logic [31:0] OP_BEQ   = 32'h0a000000;
    localparam logic [31:0] OP_BNE   = 32'h1a000000;
    localparam logic [31:0] OP_STRB  = 32'he5c10000;
    localparam logic [31:0] OP_SYSWR = 32'he3a07004;
    localparam logic [31:0] OP_SYSRD = 32'he3a07003;
    localparam logic [31:0] OP_LEN1  = 32'he3a02001;
    localparam logic [31:0] OP_FD1   = 32'he3a00001;
    localparam logic [31:0] OP_FD0   = 32'he3a00000;
    localparam logic [31:0] OP_SVC   = 32'hef000000;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_MOVE_BIG  = 3'd1;
    localparam logic [2:0] ST_STACK_FUL = 3'd2;
    localparam logic [2:0] ST_UNMATCHED = 3'd3;
    localparam logic [2:0] ST_UNCLOSED  = 3'd4;
    localparam logic [2:0] ST_CODE_FULL = 3'd5;

    localparam logic [7:0] CFG_MAX_DEPTH = 8'd0;
    localparam logic [7:0] CFG_START     = 8'd1;

    typedef enum logic [2:0] {
        FL_NONE  = 3'd0,
        FL_ADD   = 3'd1,
        FL_SUB   = 3'd2,
        FL_RIGHT = 3'd3,
        FL_LEFT  = 3'd4,
        FL_LOAD  = 3'd5
    } flush_op_t;

    typedef enum logic [1:0] {
        BY_NONE  = 2'd0,
        BY_OPEN  = 2'd1,
        BY_CLOSE = 2'd2,
        BY_IO    = 2'd3
    } byte_op_t;

    typedef struct packed {
        flush_op_t           flush_op;
        logic [11:0]         count;
        logic [1:0]          flush_len;
        byte_op_t            byte_op;
        logic                io_in;
        logic                io_first;
        logic [CODE_AW-1:0]  addr;
        logic [2:0]          nwords;
        logic [23:0]         bwd;
        logic                has_patch;
        logic [CODE_AW-1:0]  patch_addr;
        logic [23:0]         fwd;
        logic                has_status;
        logic [2:0]          status;
    } desc_t;

endpackage

// ===== hdl/loop_language_arm_code_emitter.sv =====
// A source beat is registered, then classified and committed to the descriptor queue
// once it has room; any results leave through the output register. The front takes
// no new source beat until done with the current one. One result beat per cycle
// leaves while the receiver is ready; this sets the sustained rate for multi-result beats.
// Reset: synchronous, active low; clears run, stack depth, halt and queue state and
// loads the register defaults. The bracket stack memory needs no clearing pass.
module loop_language_arm_code_emitter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] source_byte
    input  logic        s_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [15:0] word_address, [47:16] code_word, [50:48] status
    output logic        m_tuser,   // [0] writes_word
    output logic        m_tlast
);
    logic             q_push, q_pop, q_full, q_empty;
    llace_pkg::desc_t q_in, q_head;
    logic [15:0]      addr;
    logic [31:0]      word;
    logic [2:0]       status;

    assign cfg_ready = 1'b1;

    llace_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_byte   (s_tdata),
        .in_finish (s_tlast),
        .cfg_we    (cfg_valid),
        .cfg_idx   (cfg_index),
        .cfg_wdata (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    llace_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    llace_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_empty    (q_empty),
        .head       (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_addr   (addr),
        .out_word   (word),
        .out_wr     (m_tuser),
        .out_status (status),
        .out_last   (m_tlast)
    );

    assign m_tdata = {5'd0, status, word, addr};

`ifndef SYNTH
    a_write_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> status == llace_pkg::ST_OK)
        else $error("write beat carries a status code");
    a_status_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> addr == '0 && word == '0 && m_tlast)
        else $error("status beat is not a clean final beat");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("descriptor pushed into a full queue");
`endif
endmodule

// ===== hdl/llace_queue.sv =====
// Short descriptor queue between the front and the back of the code emitter.
// Depends on llace_pkg for the descriptor type and depth.
module llace_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  llace_pkg::desc_t push_data,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output llace_pkg::desc_t head
);
    llace_pkg::desc_t                  mem_reg [llace_pkg::QUEUE_DEPTH];
    logic [llace_pkg::QUEUE_AW-1:0]    wr_ptr_reg;
    logic [llace_pkg::QUEUE_AW-1:0]    rd_ptr_reg;
    logic [llace_pkg::QUEUE_AW:0]      count_reg;

    assign full  = (count_reg == (llace_pkg::QUEUE_AW+1)'(llace_pkg::QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push && !full, pop && !empty})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end
endmodule

// ===== hdl/llace_front.sv =====
// Front of the code emitter: accepts source beats, tracks runs, addresses and the
// bracket stack, and turns each beat into at most one descriptor. Depends on llace_pkg.
module llace_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [7:0]       in_byte,
    input  logic             in_finish,
    input  logic             cfg_we,
    input  logic [7:0]       cfg_idx,
    input  logic [15:0]      cfg_wdata,
    input  logic             q_full,
    output logic             q_push,
    output llace_pkg::desc_t q_data
);
    localparam int DW = llace_pkg::STACK_DW;
    localparam int AW = llace_pkg::STACK_AW;
    localparam int WW = llace_pkg::WI_W;

    logic              phase_reg;
    logic [7:0]        byte_reg;
    logic              fin_reg;
    logic [7:0]        max_depth_reg;
    logic [15:0]       start_reg;
    logic [7:0]        run_char_reg;
    logic [11:0]       run_count_reg;
    logic              run_ovf_reg;
    logic [WW-1:0]     wi_reg;
    logic [DW-1:0]     depth_reg;
    logic              halted_reg;
    logic [15:0]       top_reg;
    logic [15:0]       stack_mem [llace_pkg::STACK_DEPTH];

    logic              active, ext, do_flush, flush_err, commit;
    llace_pkg::flush_op_t fop;
    llace_pkg::byte_op_t  bop;
    logic [1:0]        flen;
    logic [2:0]        blen;
    logic [3:0]        total;
    logic [2:0]        berr;
    logic [15:0]       lim;
    logic [WW-1:0]     wi_flush, wi_total, room;
    logic [15:0]       at;
    logic [23:0]       cur24, back24;
    logic [2:0]        n;
    logic              has_st, has_patch;
    logic [2:0]        st;
    logic              ok;
    logic [AW-1:0]     rd_addr;

    function automatic llace_pkg::flush_op_t flush_class(input logic [7:0] c);
        case (c)
            8'h2b:   return llace_pkg::FL_ADD;
            8'h2d:   return llace_pkg::FL_SUB;
            8'h3e:   return llace_pkg::FL_RIGHT;
            8'h3c:   return llace_pkg::FL_LEFT;
            8'h2e:   return llace_pkg::FL_LOAD;
            8'h2c:   return llace_pkg::FL_LOAD;
            default: return llace_pkg::FL_NONE;
        endcase
    endfunction

    function automatic llace_pkg::byte_op_t byte_class(input logic [7:0] c);
        case (c)
            8'h5b:   return llace_pkg::BY_OPEN;
            8'h5d:   return llace_pkg::BY_CLOSE;
            8'h2e:   return llace_pkg::BY_IO;
            8'h2c:   return llace_pkg::BY_IO;
            default: return llace_pkg::BY_NONE;
        endcase
    endfunction

    assign in_ready = !phase_reg;
    assign rd_addr  = AW'(depth_reg - 1'b1);

    always_comb begin
        active   = (run_count_reg != '0) || run_ovf_reg;
        ext      = !fin_reg && (byte_reg == run_char_reg) && active;
        do_flush = !ext && active;
        fop      = do_flush ? flush_class(run_char_reg) : llace_pkg::FL_NONE;
        flush_err = 1'b0;
        case (fop)
            llace_pkg::FL_ADD, llace_pkg::FL_SUB, llace_pkg::FL_LOAD: flen = 2'd1;
            llace_pkg::FL_RIGHT, llace_pkg::FL_LEFT: begin
                flen      = run_ovf_reg ? 2'd0 : 2'd2;
                flush_err = run_ovf_reg;
            end
            default: flen = 2'd0;
        endcase
        bop = fin_reg ? llace_pkg::BY_NONE : byte_class(byte_reg);
        lim = (16'(max_depth_reg) > 16'(llace_pkg::STACK_DEPTH)) ?
              16'(llace_pkg::STACK_DEPTH) : 16'(max_depth_reg);
        berr = llace_pkg::ST_OK;
        case (bop)
            llace_pkg::BY_OPEN: begin
                blen = 3'd2;
                if (16'(depth_reg) >= lim) berr = llace_pkg::ST_STACK_FUL;
            end
            llace_pkg::BY_CLOSE: begin
                blen = 3'd2;
                if (depth_reg == '0) berr = llace_pkg::ST_UNMATCHED;
            end
            llace_pkg::BY_IO: blen = ext ? 3'd2 : 3'd5;
            default: blen = 3'd0;
        endcase
        total    = 4'(flen) + 4'(blen);
        wi_flush = wi_reg + WW'(flen);
        wi_total = wi_reg + WW'(total);
        room     = WW'(llace_pkg::CODE_WORDS) - wi_reg;
        at       = 16'(wi_flush + 1'b1);
        cur24    = 24'(at);
        back24   = 24'(top_reg);
        has_patch = 1'b0;
        has_st   = 1'b0;
        st       = llace_pkg::ST_OK;
        n        = 3'(total);
        if (flush_err) begin
            has_st = 1'b1;
            st     = llace_pkg::ST_MOVE_BIG;
            n      = 3'd0;
        end else if (wi_flush > WW'(llace_pkg::CODE_WORDS)) begin
            has_st = 1'b1;
            st     = llace_pkg::ST_CODE_FULL;
            n      = room[2:0];
        end else if (berr != llace_pkg::ST_OK) begin
            has_st = 1'b1;
            st     = berr;
            n      = 3'(flen);
        end else if (wi_total > WW'(llace_pkg::CODE_WORDS)) begin
            has_st = 1'b1;
            st     = llace_pkg::ST_CODE_FULL;
            n      = room[2:0];
        end else begin
            has_patch = (bop == llace_pkg::BY_CLOSE);
            if (fin_reg) begin
                has_st = 1'b1;
                st     = (depth_reg != '0) ? llace_pkg::ST_UNCLOSED : llace_pkg::ST_OK;
            end
        end
        ok = (st == llace_pkg::ST_OK);
        commit = phase_reg && !halted_reg && !q_full;

        q_data.flush_op   = fop;
        q_data.count      = run_count_reg;
        q_data.flush_len  = flen;
        q_data.byte_op    = bop;
        q_data.io_in      = (byte_reg == 8'h2c);
        q_data.io_first   = !ext;
        q_data.addr       = wi_reg[llace_pkg::CODE_AW-1:0];
        q_data.nwords     = n;
        q_data.bwd        = back24 - cur24 - 24'd1;
        q_data.has_patch  = has_patch;
        q_data.patch_addr = top_reg;
        q_data.fwd        = cur24 - back24 - 24'd1;
        q_data.has_status = has_st;
        q_data.status     = st;
        q_push = commit && ((n != '0) || has_st || has_patch);
    end

    always_ff @(posedge aclk) begin
        top_reg <= stack_mem[rd_addr];
        if (commit && ok && bop == llace_pkg::BY_OPEN) begin
            stack_mem[depth_reg[AW-1:0]] <= at;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && !phase_reg) begin
            byte_reg <= in_byte;
            fin_reg  <= in_finish;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= 1'b0;
            max_depth_reg <= 8'd100;
            start_reg     <= 16'd4;
            run_char_reg  <= '0;
            run_count_reg <= '0;
            run_ovf_reg   <= 1'b0;
            wi_reg        <= WW'(4);
            depth_reg     <= '0;
            halted_reg    <= 1'b0;
        end else begin
            if (cfg_we && cfg_idx == llace_pkg::CFG_MAX_DEPTH) begin
                max_depth_reg <= cfg_wdata[7:0];
            end
            if (cfg_we && cfg_idx == llace_pkg::CFG_START) begin
                start_reg <= cfg_wdata;
                wi_reg    <= WW'(cfg_wdata);
            end
            if (in_valid && !phase_reg) begin
                phase_reg <= 1'b1;
            end else if (phase_reg && halted_reg) begin
                phase_reg <= 1'b0;
            end else if (commit) begin
                phase_reg <= 1'b0;
                if (!ok) begin
                    halted_reg <= 1'b1;
                end else if (fin_reg) begin
                    run_char_reg  <= '0;
                    run_count_reg <= '0;
                    run_ovf_reg   <= 1'b0;
                    wi_reg        <= WW'(start_reg);
                    depth_reg     <= '0;
                end else begin
                    wi_reg <= wi_total;
                    if (ext) begin
                        run_count_reg <= run_count_reg + 1'b1;
                        if (run_count_reg == 12'hfff) run_ovf_reg <= 1'b1;
                    end else begin
                        run_char_reg  <= byte_reg;
                        run_count_reg <= 12'd1;
                        run_ovf_reg   <= 1'b0;
                    end
                    if (bop == llace_pkg::BY_OPEN) depth_reg <= depth_reg + 1'b1;
                    if (bop == llace_pkg::BY_CLOSE) depth_reg <= depth_reg - 1'b1;
                end
            end
        end
    end
endmodule

// ===== hdl/llace_back.sv =====
// Back of the code emitter: expands each queued descriptor into result beats,
// one per cycle unless stalled, via registered output. Depends on llace_pkg.
module llace_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_empty,
    input  llace_pkg::desc_t head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [15:0]      out_addr,
    output logic [31:0]      out_word,
    output logic             out_wr,
    output logic [2:0]       out_status,
    output logic             out_last
);
    logic        valid_reg;
    logic [2:0]  slot_reg;
    logic [15:0] addr_reg;
    logic [31:0] word_reg;
    logic        wr_reg;
    logic [2:0]  status_reg;
    logic        last_reg;

    logic        advance, fire, is_last;
    logic [3:0]  total;
    logic [2:0]  bidx, iidx;
    logic [31:0] word;

    always_comb begin
        advance = !valid_reg || out_ready;
        fire    = advance && !q_empty;
        total   = 4'(head.nwords) + 4'(head.has_patch) + 4'(head.has_status);
        is_last = (4'(slot_reg) == total - 4'd1);
        q_pop   = fire && is_last;
        bidx    = slot_reg - 3'(head.flush_len);
        iidx    = head.io_first ? bidx : bidx + 3'd3;
        word    = '0;
        if (slot_reg < 3'(head.flush_len)) begin
            case (head.flush_op)
                llace_pkg::FL_ADD: word = llace_pkg::OP_ADD | 32'(head.count[7:0]);
                llace_pkg::FL_SUB: word = llace_pkg::OP_SUB | 32'(head.count[7:0]);
                llace_pkg::FL_RIGHT: word = (slot_reg == 3'd0) ?
                    (llace_pkg::OP_STRBR | 32'(head.count)) : llace_pkg::OP_LDRB;
                llace_pkg::FL_LEFT: word = (slot_reg == 3'd0) ?
                    (llace_pkg::OP_STRBL | 32'(head.count)) : llace_pkg::OP_LDRB;
                llace_pkg::FL_LOAD: word = llace_pkg::OP_LDRB;
                default: word = '0;
            endcase
        end else begin
            case (head.byte_op)
                llace_pkg::BY_OPEN:
                    word = (bidx == 3'd0) ? llace_pkg::OP_TST : llace_pkg::OP_BEQ;
                llace_pkg::BY_CLOSE:
                    word = (bidx == 3'd0) ? llace_pkg::OP_TST :
                           (llace_pkg::OP_BNE | 32'(head.bwd));
                llace_pkg::BY_IO: begin
                    case (iidx)
                        3'd0:    word = llace_pkg::OP_STRB;
                        3'd1:    word = head.io_in ? llace_pkg::OP_SYSRD : llace_pkg::OP_SYSWR;
                        3'd2:    word = llace_pkg::OP_LEN1;
                        3'd3:    word = head.io_in ? llace_pkg::OP_FD0 : llace_pkg::OP_FD1;
                        default: word = llace_pkg::OP_SVC;
                    endcase
                end
                default: word = '0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            last_reg <= is_last;
            if (slot_reg < head.nwords) begin
                addr_reg   <= head.addr + 16'(slot_reg);
                word_reg   <= word;
                wr_reg     <= 1'b1;
                status_reg <= llace_pkg::ST_OK;
            end else if (slot_reg == head.nwords && head.has_patch) begin
                addr_reg   <= head.patch_addr;
                word_reg   <= llace_pkg::OP_BEQ | 32'(head.fwd);
                wr_reg     <= 1'b1;
                status_reg <= llace_pkg::ST_OK;
            end else begin
                addr_reg   <= '0;
                word_reg   <= '0;
                wr_reg     <= 1'b0;
                status_reg <= head.status;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            slot_reg  <= '0;
        end else if (advance) begin
            valid_reg <= fire;
            if (fire) begin
                slot_reg <= is_last ? 3'd0 : slot_reg + 3'd1;
            end
        end
    end

    assign out_valid  = valid_reg;
    assign out_addr   = addr_reg;
    assign out_word   = word_reg;
    assign out_wr     = wr_reg;
    assign out_status = status_reg;
    assign out_last   = last_reg;
endmodule

// ===== dv/tb_loop_language_arm_code_emitter.sv =====
// Self-checking testbench for loop_language_arm_code_emitter: drives source and register beats,
// predicts every code write and status beat and compares them in order at the result port.
// Depends on llace_pkg and the emitter RTL only.
module tb_loop_language_arm_code_emitter;

    localparam logic [7:0] CH_INC   = 8'h2b;
    localparam logic [7:0] CH_DEC   = 8'h2d;
    localparam logic [7:0] CH_RIGHT = 8'h3e;
    localparam logic [7:0] CH_LEFT  = 8'h3c;
    localparam logic [7:0] CH_OPEN  = 8'h5b;
    localparam logic [7:0] CH_CLOSE = 8'h5d;
    localparam logic [7:0] CH_OUT   = 8'h2e;
    localparam logic [7:0] CH_IN    = 8'h2c;
    localparam logic [7:0] CH_OTHER = 8'h78;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct packed {
        logic [15:0] addr;
        logic [31:0] word;
        logic        wr;
        logic [2:0]  st;
        logic        lst;
    } code_beat_t;

    typedef enum int {ERR_STACK, ERR_CLOSE, ERR_OPEN, ERR_CODE} final_err_t;

    class emitter_scoreboard;
        int unsigned max_depth, start_idx, run_char, run_count, wr_idx, depth;
        bit          run_ovf, halted;
        logic [31:0] bracket_addr [llace_pkg::STACK_DEPTH];
        code_beat_t  expected_beats [$];
        code_beat_t  step_beats [$];
        int          errors;

        function new();
            max_depth = 100;
            start_idx = 4;
            wr_idx    = 4;
        endfunction

        function int unsigned depth_limit();
            return (max_depth > llace_pkg::STACK_DEPTH) ? llace_pkg::STACK_DEPTH : max_depth;
        endfunction

        function void put(logic [31:0] addr, logic [31:0] word, logic wr, logic [2:0] st);
            code_beat_t b;
            b.addr = addr[15:0];
            b.word = word;
            b.wr   = wr;
            b.st   = st;
            b.lst  = 1'b0;
            if (step_beats.size() < 7) step_beats.push_back(b);
        endfunction

        function void fail(logic [2:0] st);
            put(0, 0, 1'b0, st);
            halted = 1'b1;
        endfunction

        function bit emit(logic [31:0] word);
            if (wr_idx >= llace_pkg::CODE_WORDS) begin
                fail(llace_pkg::ST_CODE_FULL);
                return 1'b0;
            end
            put(wr_idx, word, 1'b1, llace_pkg::ST_OK);
            wr_idx++;
            return 1'b1;
        endfunction

        function void flush_run();
            case (run_char)
                CH_INC: void'(emit(llace_pkg::OP_ADD | (run_count & 8'hff)));
                CH_DEC: void'(emit(llace_pkg::OP_SUB | (run_count & 8'hff)));
                CH_RIGHT, CH_LEFT: begin
                    if (run_ovf) fail(llace_pkg::ST_MOVE_BIG);
                    else if (emit(((run_char == CH_RIGHT) ? llace_pkg::OP_STRBR :
                                   llace_pkg::OP_STRBL) | (run_count & 12'hfff)))
                        void'(emit(llace_pkg::OP_LDRB));
                end
                CH_OUT, CH_IN: void'(emit(llace_pkg::OP_LDRB));
                default: ;
            endcase
        endfunction

        function void per_byte(logic [7:0] c, bit first);
            logic [31:0] back, cur;
            if (c == CH_OPEN) begin
                if (depth >= depth_limit()) begin
                    fail(llace_pkg::ST_STACK_FUL);
                    return;
                end
                back = wr_idx + 1;
                if (emit(llace_pkg::OP_TST) && emit(llace_pkg::OP_BEQ)) begin
                    bracket_addr[depth] = back;
                    depth++;
                end
            end else if (c == CH_CLOSE) begin
                if (depth == 0) begin
                    fail(llace_pkg::ST_UNMATCHED);
                    return;
                end
                depth--;
                back = bracket_addr[depth];
                cur  = wr_idx + 1;
                if (emit(llace_pkg::OP_TST) &&
                    emit(llace_pkg::OP_BNE | ((back - cur - 1) & 32'hffffff)))
                    put(back, llace_pkg::OP_BEQ | ((cur - back - 1) & 32'hffffff), 1'b1,
                        llace_pkg::ST_OK);
            end else if (c == CH_OUT || c == CH_IN) begin
                if (first) begin
                    if (!emit(llace_pkg::OP_STRB)) return;
                    if (!emit((c == CH_OUT) ? llace_pkg::OP_SYSWR : llace_pkg::OP_SYSRD)) return;
                    if (!emit(llace_pkg::OP_LEN1)) return;
                end
                if (emit((c == CH_OUT) ? llace_pkg::OP_FD1 : llace_pkg::OP_FD0))
                    void'(emit(llace_pkg::OP_SVC));
            end
        endfunction

        function void note_source(logic [7:0] b, logic fin);
            bit active;
            step_beats.delete();
            if (!halted) begin
                active = (run_count != 0) || run_ovf;
                if (fin) begin
                    if (active) flush_run();
                    if (!halted) begin
                        if (depth != 0) fail(llace_pkg::ST_UNCLOSED);
                        else begin
                            put(0, 0, 1'b0, llace_pkg::ST_OK);
                            run_char  = 0;
                            run_count = 0;
                            run_ovf   = 1'b0;
                            wr_idx    = start_idx;
                        end
                    end
                end else if (b == run_char && active) begin
                    run_count = (run_count + 1) & 12'hfff;
                    if (run_count == 0) run_ovf = 1'b1;
                    per_byte(b, 1'b0);
                end else begin
                    if (active) flush_run();
                    if (!halted) begin
                        run_char  = b;
                        run_count = 1;
                        run_ovf   = 1'b0;
                        per_byte(b, 1'b1);
                    end
                end
            end
            if (step_beats.size() > 0) step_beats[step_beats.size() - 1].lst = 1'b1;
            foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] val);
            if (idx == llace_pkg::CFG_MAX_DEPTH) max_depth = val[7:0];
            else if (idx == llace_pkg::CFG_START) begin
                start_idx = val;
                wr_idx    = val;
            end
        endfunction

        function void check_beat(code_beat_t got);
            code_beat_t want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                errors++;
                return;
            end
            want = expected_beats.pop_front();
            if (got.addr != want.addr || got.word != want.word || got.wr != want.wr
                    || got.st != want.st || got.lst != want.lst) begin
                $display("%0t: mismatch, expected addr %h word %h wr %b st %0d last %b",
                         $time, want.addr, want.word, want.wr, want.st, want.lst);
                $display("%0t:           actual addr %h word %h wr %b st %0d last %b",
                         $time, got.addr, got.word, got.wr, got.st, got.lst);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid, s_tready, s_tlast;
    logic [7:0]  s_tdata;
    logic        cfg_valid, cfg_ready;
    logic [7:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        m_tvalid, m_tready, m_tuser, m_tlast;
    logic [55:0] m_tdata;

    emitter_scoreboard sb = new();
    int  send_idle, recv_idle;
    bit  hold_req;
    bit  hold_used;
    int  hold_cnt;
    int  cycles;

    loop_language_arm_code_emitter u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge aclk) begin
        code_beat_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.addr = m_tdata[15:0];
            got.word = m_tdata[47:16];
            got.st   = m_tdata[50:48];
            got.wr   = m_tuser;
            got.lst  = m_tlast;
            sb.check_beat(got);
        end
    end

    // The receiver idles at random, or holds off once for a long stretch on request.
    always @(negedge aclk) begin
        if (hold_req && !hold_used && hold_cnt == 0) begin
            hold_cnt  <= 400;
            hold_used <= 1'b1;
            m_tready  <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= (hold_cnt == 1);
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic send_source(logic [7:0] b, logic fin);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= fin;
        do @(posedge aclk); while (!s_tready);
        sb.note_source(b, fin);
        @(negedge aclk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [15:0] val);
        s_tvalid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.expected_beats.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic close_and_finish();
        while (sb.depth != 0) send_source(CH_CLOSE, 1'b0);
        send_source(8'($urandom), 1'b1);
    endtask

    task automatic random_source(int n);
        logic [7:0] cmds [8] = '{CH_INC, CH_DEC, CH_RIGHT, CH_LEFT,
                                 CH_OPEN, CH_CLOSE, CH_OUT, CH_IN};
        logic [7:0] b, prev;
        int r;
        prev = CH_INC;
        repeat (n) begin
            r = $urandom_range(99);
            if (r < 4) begin
                if (sb.depth == 0) send_source(8'($urandom), 1'b1);
                else send_source(CH_CLOSE, 1'b0);
                continue;
            end
            if (r < 30) b = prev;
            else if (r < 88) b = cmds[$urandom_range(7)];
            else b = 8'($urandom);
            if (b == CH_OPEN && sb.depth >= sb.depth_limit()) b = CH_OUT;
            if (b == CH_CLOSE && sb.depth == 0) b = CH_INC;
            send_source(b, 1'b0);
            prev = b;
        end
        close_and_finish();
    endtask

    initial begin
        logic [7:0] directed [] = '{8'h00, CH_INC, CH_INC, CH_INC, 8'hff, CH_DEC, CH_DEC,
                                    CH_RIGHT, CH_RIGHT, CH_RIGHT, CH_LEFT, CH_OPEN, CH_OPEN,
                                    CH_OUT, CH_OUT, CH_IN, CH_CLOSE, CH_CLOSE, CH_IN,
                                    CH_LEFT, CH_OTHER};
        final_err_t err;
        cycles    = 0;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tlast   = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = 8'h00;
        cfg_data  = 16'h0000;
        m_tready  = 1'b0;
        hold_req  = 1'b0;
        hold_used = 1'b0;
        hold_cnt  = 0;
        send_idle = 0;
        recv_idle = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) send_source(directed[i], 1'b0);
        send_source(8'h00, 1'b1);
        drain();

        send_idle = 11;
        recv_idle = 71;
        write_reg(llace_pkg::CFG_MAX_DEPTH, 16'd1);
        write_reg(llace_pkg::CFG_START, 16'd0);
        random_source(85);
        drain();

        send_idle = 71;
        recv_idle = 11;
        write_reg(llace_pkg::CFG_MAX_DEPTH, 16'd128);
        write_reg(llace_pkg::CFG_START, 16'($urandom_range(1000, 60000)));
        random_source(85);
        drain();

        send_idle = 0;
        recv_idle = 0;
        write_reg(llace_pkg::CFG_MAX_DEPTH, 16'($urandom_range(2, 128)));
        write_reg(llace_pkg::CFG_START, 16'($urandom_range(0, 200)));
        hold_req = 1'b1;
        random_source(85);
        hold_req = 1'b0;
        drain();

        // A single error halts the block for the rest of the run, so it comes last.
        err = final_err_t'($urandom_range(3));
        case (err)
            ERR_STACK: repeat (sb.depth_limit() + 1) send_source(CH_OPEN, 1'b0);
            ERR_CLOSE: send_source(CH_CLOSE, 1'b0);
            ERR_OPEN: begin
                send_source(CH_OPEN, 1'b0);
                send_source(8'h00, 1'b1);
            end
            default: begin
                write_reg(llace_pkg::CFG_START, 16'hffff);
                send_source(CH_OUT, 1'b0);
            end
        endcase
        repeat (5) send_source(8'($urandom), 1'($urandom));
        drain();

        if (sb.errors == 0 && sb.expected_beats.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
